// ===== design/fifo_queue_with_remove_by_value_defines.svh =====
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value_defines
// Assertion macros shared by the queue block.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_REMOVE_BY_VALUE_DEFINES_SVH
`define FIFO_QUEUE_WITH_REMOVE_BY_VALUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define FQRV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define FQRV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fqrv_pkg.sv =====
// ----------------------------------------------------------------------------
// fqrv_pkg
// Types and constants for the queue with remove by value.
// ----------------------------------------------------------------------------
package fqrv_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [DEPTH-1:0] LSB_VEC = DEPTH'(1);

    typedef enum logic [1:0] {
        FN_ENQ = 2'd0,
        FN_DEQ = 2'd1,
        FN_REM = 2'd2,
        FN_NOP = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_EMPTY    = 2'd1,
        STS_FULL     = 2'd2,
        STS_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        func_t              func;
        logic signed [31:0] item_value;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] out_value;
        logic [CNT_W-1:0]   fill_level;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } dp_ctl_t;

endpackage

// ===== design/fqrv_ctrl.sv =====
// ----------------------------------------------------------------------------
// fqrv_ctrl
// Sequencer: takes one transaction, runs compare then commit, owns rsp valid.
// ----------------------------------------------------------------------------
module fqrv_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output fqrv_pkg::dp_ctl_t ctl
);
    import fqrv_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   out_free;

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd_stall   = 1'b1;
        ctl.capture = 1'b0;
        ctl.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall   = 1'b0;
                ctl.capture = cmd_valid;
            end
            S_EXEC:
            begin
                ctl.commit = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    // Hold the response until taken, load it on commit
    always_comb
    begin
        priority if (ctl.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

// ===== design/fqrv_datapath.sv =====
// ----------------------------------------------------------------------------
// fqrv_datapath
// Row of entry cells with compare, first-match pick, shift and fill count.
// ----------------------------------------------------------------------------
module fqrv_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  fqrv_pkg::dp_ctl_t ctl,
    input  fqrv_pkg::cmd_t    cmd,
    output fqrv_pkg::rsp_t    rsp
);
    import fqrv_pkg::*;

    logic signed [31:0] entries_reg  [DEPTH];
    logic signed [31:0] entries_next [DEPTH];
    func_t              func_reg;
    logic signed [31:0] value_reg;
    logic [DEPTH-1:0]   match_reg;
    logic [DEPTH-1:0]   match_next;
    logic [CNT_W-1:0]   occ_reg;
    logic [CNT_W-1:0]   occ_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               full;
    logic               empty;
    logic               found;
    logic               do_enq;
    logic               do_shift;
    logic [DEPTH-1:0]   first_hit;
    logic [DEPTH-1:0]   sel;
    logic [DEPTH-1:0]   shift_mask;

    assign full  = (occ_reg == CNT_W'(DEPTH));
    assign empty = (occ_reg == '0);
    assign found = |match_reg;

    // Isolate the match nearest the head; dequeue starts the shift at the head
    assign first_hit  = match_reg & (~match_reg + LSB_VEC);
    assign sel        = (func_reg == FN_DEQ) ? LSB_VEC : first_hit;
    assign shift_mask = ~(sel - LSB_VEC);
    assign do_enq     = (func_reg == FN_ENQ) && !full;
    assign do_shift   = ((func_reg == FN_DEQ) && !empty) || ((func_reg == FN_REM) && found);

    // Per-entry cells: compare against the key, shift down or take the new value
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [31:0] upper;

        if (g < DEPTH - 1)
        begin : g_mid
            assign upper = entries_reg[g+1];
        end
        else
        begin : g_top
            assign upper = entries_reg[g];
        end

        assign match_next[g] = (CNT_W'(g) < occ_reg) && (entries_reg[g] == cmd.item_value);

        always_comb
        begin
            priority if (do_shift && shift_mask[g])
            begin
                entries_next[g] = upper;
            end
            else if (do_enq && (IDX_W'(g) == occ_reg[IDX_W-1:0]))
            begin
                entries_next[g] = value_reg;
            end
            else
            begin
                entries_next[g] = entries_reg[g];
            end
        end
    end

    // Build the response and the new fill count
    always_comb
    begin
        rsp_next.status    = STS_OK;
        rsp_next.out_value = '0;
        occ_next           = occ_reg;
        unique case (func_reg)
            FN_ENQ:
            begin
                if (full)
                begin
                    rsp_next.status = STS_FULL;
                end
                else
                begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            FN_DEQ:
            begin
                if (empty)
                begin
                    rsp_next.status = STS_EMPTY;
                end
                else
                begin
                    rsp_next.out_value = entries_reg[0];
                    occ_next           = occ_reg - CNT_W'(1);
                end
            end
            FN_REM:
            begin
                priority if (empty)
                begin
                    rsp_next.status = STS_EMPTY;
                end
                else if (found)
                begin
                    rsp_next.out_value = value_reg;
                    occ_next           = occ_reg - CNT_W'(1);
                end
                else
                begin
                    rsp_next.status = STS_NOTFOUND;
                end
            end
            FN_NOP:
            begin
                rsp_next.status = STS_OK;
            end
            default:
            begin
                rsp_next.status = STS_OK;
            end
        endcase
        rsp_next.fill_level = occ_next;
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else if (ctl.commit)
        begin
            occ_reg <= occ_next;
        end
    end

    // Capture the command and the compare result, then commit
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            func_reg  <= cmd.func;
            value_reg <= cmd.item_value;
            match_reg <= match_next;
        end
        if (ctl.commit)
        begin
            entries_reg <= entries_next;
            rsp_reg     <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ===== design/fifo_queue_with_remove_by_value.sv =====
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_value
// Bounded FIFO of signed 32-bit values with enqueue, dequeue and remove.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_stall, cmd) carries one operation per
//   transaction: enqueue, dequeue head, remove first entry equal to the
//   value, or no operation. rsp channel (rsp_valid/rsp_stall, rsp) returns
//   exactly one transaction per command: status, removed value and the fill
//   level after the operation.
//   Sequence: the accepting edge registers the command and the per-entry
//   compare vector; the commit edge picks the first match, shifts the cells
//   above it down by one, loads the response register and raises rsp_valid.
//   A new command is not taken until the current one has committed, set by
//   that compare/commit sequence through the single row of entry cells.
//   A new command is taken while a finished response still waits; if the
//   receiver stalls, the next command waits in the commit step until the
//   response register is free.
//   Reset empties the queue at once (fill count zero); entry contents are
//   left as they are and only held entries are ever read.
// ----------------------------------------------------------------------------
`include "fifo_queue_with_remove_by_value_defines.svh"

module fifo_queue_with_remove_by_value (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  fqrv_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fqrv_pkg::rsp_t rsp
);
    import fqrv_pkg::*;

    dp_ctl_t ctl;

    // Sequencer
    fqrv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    // Entry cells and response register
    fqrv_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // Checks
    `FQRV_ASSERT_NOW(a_fill_bound, rsp_valid, rsp.fill_level <= CNT_W'(DEPTH), "fill level above depth")
    `FQRV_ASSERT_NOW(a_full_level, rsp_valid && (rsp.status == STS_FULL), rsp.fill_level == CNT_W'(DEPTH), "full status with room left")
    `FQRV_ASSERT_NOW(a_empty_level, rsp_valid && (rsp.status == STS_EMPTY), (rsp.fill_level == '0) && (rsp.out_value == '0), "empty status with entries held")
    `FQRV_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "second command taken during execution")

endmodule
